@@ src/led_status_pattern_generator_core_macros.svh @@
// Assertion macros for the LED status pattern generator.
// No dependencies.
`ifndef LED_STATUS_PATTERN_GENERATOR_CORE_MACROS_SVH
`define LED_STATUS_PATTERN_GENERATOR_CORE_MACROS_SVH
// implication checked on every clock edge outside reset
`define LSPG_ASSERT_IMP(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
        else $error("assertion failed");
// next-cycle implication
`define LSPG_ASSERT_NXT(label, clk, rstn, a, c) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
        else $error("assertion failed");
`endif

@@ src/lspg_pkg.sv @@
// Package for the LED status pattern generator: payload types, constants,
// sine table function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lspg_pkg;
    localparam int MAX_LEDS_DEF = 64;
    localparam int SINE_DEPTH_DEF = 256;
    localparam int CNT_W = 7;
    localparam logic [CNT_W-1:0] LED_COUNT_RESET = 7'd8;

    localparam logic [15:0] STEP_01  = 16'd1043;
    localparam logic [15:0] STEP_02  = 16'd2086;
    localparam logic [15:0] STEP_025 = 16'd2608;
    localparam logic [15:0] STEP_03  = 16'd3129;
    localparam logic [15:0] STEP_PIX = 16'd8344;

    localparam logic [4:0] M_BOOT = 5'd0,  M_IDLE = 5'd1,  M_MANUAL = 5'd2;
    localparam logic [4:0] M_PATROL = 5'd3, M_FLOW = 5'd4, M_FOLLOW = 5'd5;
    localparam logic [4:0] M_THINK = 5'd6, M_LISTEN = 5'd7, M_SPEAK = 5'd8;
    localparam logic [4:0] M_CAMERA = 5'd9, M_CHARGING = 5'd10, M_CHARGED = 5'd11;
    localparam logic [4:0] M_LOWBAT = 5'd12, M_CRITBAT = 5'd13, M_OBSGLOW = 5'd14;
    localparam logic [4:0] M_OBSFLASH = 5'd15, M_WIFI = 5'd16, M_MQTT = 5'd17;
    localparam logic [4:0] M_SENSERR = 5'd18, M_MOTERR = 5'd19, M_UNKNOWN = 5'd20;
    localparam logic [4:0] M_INTRUDER = 5'd21, M_GAS = 5'd22, M_ESTOP = 5'd23;
    localparam logic [4:0] M_SHUTDOWN = 5'd24;

    typedef struct packed {
        logic [4:0]  mode;
        logic [15:0] frame;
        logic [5:0]  pixel_index;
    } in_item_t;

    typedef struct packed {
        logic [7:0] front_red;
        logic [7:0] front_green;
        logic [7:0] front_blue;
        logic [7:0] back_red;
        logic [7:0] back_green;
        logic [7:0] back_blue;
    } out_item_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    // Q15 sine entry via fixed-point Taylor series; constant-folded into a ROM
    function automatic logic signed [16:0] sine_rom(input int unsigned idx,
                                                    input int unsigned depth);
        logic [63:0] a, r, x, x2, t, sum;
        logic [1:0]  quad;
        logic [31:0] mag;
        int unsigned k;
        a = (64'(idx) << 32) / 64'(depth);
        quad = a[31:30];
        r = a & 64'h3FFF_FFFF;
        if (quad[0]) r = 64'h4000_0000 - r;
        x = (r * 64'd1686629713) >> 30;
        x2 = (x * x) >> 30;
        t = x;
        sum = x;
        for (k = 1; k <= 5; k++) begin
            t = ((t * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k[0]) sum = sum - t;
            else sum = sum + t;
        end
        mag = 32'((sum + 64'd16384) >> 15);
        return quad[1] ? -17'(signed'(mag[16:0])) : 17'(mag[16:0]);
    endfunction
endpackage
`default_nettype wire

@@ src/led_status_pattern_generator_core.sv @@
// LED status pattern generator, top level. Depends on lspg_pkg and macros header.
// Four register stages, the first loaded at the accepting edge; throughput 1 item per
// cycle while m_ready does not stall the output stage, no stage loops.
// Stages: frame arithmetic and upper remainder bits, lower remainder bits and sine
// ROM read, fill remainder and level multiply, colour select.
// Stall freezes all stages; s_ready follows the output stage.
// Reset (synchronous, active low) clears stage valid bits and sets led_count to 8.
`timescale 1ns / 1ps
`default_nettype none
`include "led_status_pattern_generator_core_macros.svh"
module led_status_pattern_generator_core #(
    parameter int MAX_LEDS = lspg_pkg::MAX_LEDS_DEF,
    parameter int SINE_TABLE_DEPTH = lspg_pkg::SINE_DEPTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [6:0]            cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire lspg_pkg::in_item_t    s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output lspg_pkg::out_item_t        m_data
);
    localparam int SW = $clog2(SINE_TABLE_DEPTH);

    // sine ROM as constant table
    logic signed [16:0] sine_tab [SINE_TABLE_DEPTH];
    for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_rom
        assign sine_tab[gi] = lspg_pkg::sine_rom(gi, SINE_TABLE_DEPTH);
    end

    logic [6:0] led_count_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            led_count_reg <= lspg_pkg::LED_COUNT_RESET;
        end else if (cfg_we) begin
            led_count_reg <= cfg_wdata;
        end
    end

    // clamp count to the strip maximum
    logic [7:0] n_c;
    assign n_c = (32'(led_count_reg) > MAX_LEDS) ? 8'(MAX_LEDS) : {1'b0, led_count_reg};

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    assign adv = !v4_reg || m_ready;
    assign s_ready = adv;
    assign m_valid = v4_reg;

    // ---------------- stage 1: modular frame arithmetic ----------------
    typedef struct packed {
        logic [4:0]  mode;
        logic [15:0] frame;
        logic [5:0]  pix;
        logic [7:0]  n;
        logic        in_range;
        logic [7:0]  f_mod_n;
        logic [8:0]  f_mod_2n;
        logic [7:0]  flow;     // (f/2)%(half+1)
        logic [7:0]  h;        // f%(half+1)
        logic [7:0]  fill;     // (f/3)%(n+1)
        logic [14:0] f3;       // f/3
        logic        b6, b2, b3, b5, b4;
        logic        mqtt_on;
        logic [15:0] phase;
    } s1_t;
    s1_t s1_reg, s1_next;

    // eight bits of a restoring remainder; the remainder fields hold partial
    // values until the last byte has been folded in
    function automatic logic [7:0] rem8(input logic [7:0] r_in, input logic [7:0] a,
                                        input logic [8:0] d);
        logic [9:0] r;
        r = {2'b0, r_in};
        for (int i = 7; i >= 0; i--) begin
            r = {r[8:0], a[i]};
            if (r >= {1'b0, d}) r = r - {1'b0, d};
        end
        return r[7:0];
    endfunction

    always_comb begin
        logic [7:0] half;
        logic [15:0] stp;
        logic [31:0] f3p, f5p;
        half = n_c >> 1;
        // reciprocal multiplies, exact over the 16-bit frame range
        f3p = 32'(s_data.frame) * 32'd43691;
        f5p = 32'(s_data.frame) * 32'd52429;
        s1_next.mode = s_data.mode;
        s1_next.frame = s_data.frame;
        s1_next.pix = s_data.pixel_index;
        s1_next.n = n_c;
        s1_next.in_range = (n_c != 8'd0) && ({2'b0, s_data.pixel_index} < n_c);
        s1_next.f_mod_n = rem8(8'd0, s_data.frame[15:8], {1'b0, n_c} | 9'(n_c == 0));
        s1_next.f_mod_2n = {1'b0, rem8(8'd0, s_data.frame[15:8],
                                       ({1'b0, n_c} << 1) | 9'(n_c == 0))};
        s1_next.flow = rem8(8'd0, {1'b0, s_data.frame[15:9]}, 9'(half) + 9'd1);
        s1_next.h = rem8(8'd0, s_data.frame[15:8], 9'(half) + 9'd1);
        s1_next.fill = 8'd0;
        s1_next.f3 = f3p[31:17];
        s1_next.b6 = f3p[18];
        s1_next.b2 = s_data.frame[1];
        s1_next.b3 = f3p[17];
        s1_next.b5 = f5p[18];
        s1_next.b4 = s_data.frame[2];
        s1_next.mqtt_on = 1'b0;
        case (s_data.mode)
            lspg_pkg::M_IDLE, lspg_pkg::M_OBSGLOW: stp = lspg_pkg::STEP_01;
            lspg_pkg::M_FOLLOW:                    stp = lspg_pkg::STEP_02;
            lspg_pkg::M_THINK:                     stp = lspg_pkg::STEP_025;
            default:                               stp = lspg_pkg::STEP_03;
        endcase
        s1_next.phase = 16'(s_data.frame * stp);
        if (s_data.mode == lspg_pkg::M_LISTEN)
            s1_next.phase = s1_next.phase + 16'(s_data.pixel_index * lspg_pkg::STEP_PIX);
    end

    // ---------------- stage 2: sine ROM read, low remainder bits ----------------
    typedef struct packed {
        s1_t d;
        logic signed [16:0] s;
    } s2_t;
    s2_t s2_reg, s2_next;
    always_comb begin
        logic [7:0] hf;
        logic [12:0] m3;
        hf = s1_reg.n >> 1;
        // (f/8)%3 from f/24 = (f/3)/8
        m3 = s1_reg.frame[15:3] - 13'(s1_reg.f3[14:3]) * 13'd3;
        s2_next.d = s1_reg;
        s2_next.d.f_mod_n = rem8(s1_reg.f_mod_n, s1_reg.frame[7:0],
                                 {1'b0, s1_reg.n} | 9'(s1_reg.n == 8'd0));
        s2_next.d.f_mod_2n = {1'b0, rem8(s1_reg.f_mod_2n[7:0], s1_reg.frame[7:0],
                                         ({1'b0, s1_reg.n} << 1) | 9'(s1_reg.n == 8'd0))};
        s2_next.d.flow = rem8(s1_reg.flow, s1_reg.frame[8:1], 9'(hf) + 9'd1);
        s2_next.d.h = rem8(s1_reg.h, s1_reg.frame[7:0], 9'(hf) + 9'd1);
        s2_next.d.fill = rem8(8'd0, {1'b0, s1_reg.f3[14:8]}, 9'(s1_reg.n) + 9'd1);
        s2_next.d.mqtt_on = m3 < 13'd2;
        s2_next.s = sine_tab[SW'((32'(s1_reg.phase) * SINE_TABLE_DEPTH) >> 16)];
    end

    // ---------------- stage 3: level multiply, fill remainder ----------------
    typedef struct packed {
        s1_t d;
        logic [7:0] v;
    } s3_t;
    s3_t s3_reg, s3_next;
    always_comb begin
        logic signed [26:0] num;
        logic signed [8:0] off, gain;
        case (s2_reg.d.mode)
            lspg_pkg::M_IDLE:   begin off = 9'sd60;  gain = 9'sd60;  end
            lspg_pkg::M_OBSGLOW: begin off = 9'sd100; gain = 9'sd100; end
            lspg_pkg::M_LISTEN: begin off = 9'sd127; gain = 9'sd127; end
            lspg_pkg::M_FOLLOW, lspg_pkg::M_THINK: begin off = 9'sd128; gain = 9'sd127; end
            default:            begin off = 9'sd0;   gain = 9'sd0;   end
        endcase
        num = (27'(off) <<< 15) + 27'(gain) * 27'(s2_reg.s);
        s3_next.d = s2_reg.d;
        s3_next.d.fill = rem8(s2_reg.d.fill, s2_reg.d.f3[7:0], 9'(s2_reg.d.n) + 9'd1);
        s3_next.v = num[26] ? 8'd0 : num[22:15];
    end

    // ---------------- stage 4: colour select ----------------
    lspg_pkg::out_item_t out_reg, out_next;
    always_comb begin
        lspg_pkg::rgb_t fr, bk, rd, gr, wh, org, cy, yl;
        logic [7:0] n, half, p, v, lp, idx, nxt, fv;
        logic [8:0] left, right;
        logic [15:0] f;
        logic [9:0] v3;
        logic [17:0] v35;
        s1_t d;
        d = s3_reg.d;
        n = d.n; half = n >> 1; p = {2'b0, d.pix}; v = s3_reg.v; f = d.frame;
        rd = '{8'd255, 8'd0, 8'd0}; gr = '{8'd0, 8'd255, 8'd0};
        wh = '{8'd255, 8'd255, 8'd255}; org = '{8'd255, 8'd100, 8'd0};
        cy = '{8'd0, 8'd255, 8'd255}; yl = '{8'd255, 8'd255, 8'd0};
        fr = '0; bk = '0;
        idx = d.f_mod_n;
        nxt = (idx + 8'd1 == n) ? 8'd0 : idx + 8'd1;
        lp = (9'(d.f_mod_2n) < 9'(n)) ? 8'(d.f_mod_2n) : 8'(({1'b0, n} << 1) - 9'd1 - d.f_mod_2n);
        left = 9'(half) - 9'd1 - 9'(d.flow);
        right = 9'(half) + 9'(d.flow);
        v3 = 10'(v) * 10'd3;
        // divide by 5 as multiply by 205/1024, exact below 1024
        v35 = 18'(v3) * 18'd205;
        fv = (f >= 16'd64) ? 8'd0 : 8'd255 - 8'(f << 2);
        if (d.in_range) begin
            case (d.mode)
                lspg_pkg::M_BOOT: begin
                    if (p == nxt) fr = '{8'd0, 8'd150, 8'd150};
                    else if (p == idx) fr = cy;
                    bk = fr;
                end
                lspg_pkg::M_IDLE, lspg_pkg::M_FOLLOW: begin fr = '{8'd0, 8'd0, v}; bk = fr; end
                lspg_pkg::M_MANUAL: begin fr = wh; bk = rd; end
                lspg_pkg::M_PATROL: if (p == lp) begin fr = '{8'd160, 8'd0, 8'd240}; bk = fr; end
                lspg_pkg::M_FLOW:
                    if (!left[8] && right < 9'(n) && (9'(p) == left || 9'(p) == right)) begin
                        fr = gr; bk = gr;
                    end
                lspg_pkg::M_THINK: begin fr = '{v35[17:10], 8'd0, v}; bk = fr; end
                lspg_pkg::M_LISTEN: begin fr = '{8'd0, v >> 1, v}; bk = fr; end
                lspg_pkg::M_SPEAK:
                    if (9'(p) + 9'(d.h) >= 9'(half) && 9'(p) < 9'(half) + 9'(d.h)) begin
                        fr = cy; bk = cy;
                    end
                lspg_pkg::M_CAMERA: if (!d.b6 && p == 8'd0) begin fr = rd; bk = rd; end
                lspg_pkg::M_CHARGING: if (p < d.fill) begin fr = gr; bk = gr; end
                lspg_pkg::M_CHARGED: begin fr = gr; bk = gr; end
                lspg_pkg::M_LOWBAT: if (p < 8'd3) begin fr = yl; bk = yl; end
                lspg_pkg::M_CRITBAT: if (!d.b5) begin fr = rd; bk = rd; end
                lspg_pkg::M_OBSGLOW: fr = '{v, v, 8'd0};
                lspg_pkg::M_OBSFLASH: if (!d.b3) fr = rd;
                lspg_pkg::M_WIFI: begin
                    if (p == idx) fr = org;
                    if (9'(p) == ((9'(idx) + 9'(half) >= 9'(n)) ?
                                  9'(idx) + 9'(half) - 9'(n) : 9'(idx) + 9'(half))) bk = org;
                end
                lspg_pkg::M_MQTT: if (d.mqtt_on) begin fr = org; bk = org; end
                lspg_pkg::M_SENSERR:
                    if (!d.b5 && ((half != 0 && p == half - 8'd1) || p == half)) begin
                        fr = rd; bk = rd;
                    end
                lspg_pkg::M_MOTERR:
                    if (!d.b4 && (p == 8'd0 || p == n - 8'd1)) begin fr = rd; bk = rd; end
                lspg_pkg::M_UNKNOWN: begin fr = d.b6 ? wh : rd; bk = d.b6 ? rd : wh; end
                lspg_pkg::M_INTRUDER: begin fr = d.b2 ? wh : rd; bk = d.b2 ? rd : wh; end
                lspg_pkg::M_GAS: begin fr = d.b3 ? org : rd; bk = d.b3 ? rd : org; end
                lspg_pkg::M_ESTOP: if (!f[0]) begin fr = rd; bk = rd; end
                lspg_pkg::M_SHUTDOWN: begin fr = '{8'd0, fv, fv}; bk = fr; end
                default: ;
            endcase
        end
        out_next = {fr.r, fr.g, fr.b, bk.r, bk.g, bk.b};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_valid; v2_reg <= v1_reg; v3_reg <= v2_reg; v4_reg <= v3_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg <= s1_next; s2_reg <= s2_next; s3_reg <= s3_next; out_reg <= out_next;
        end
    end
    assign m_data = out_reg;

    `LSPG_ASSERT_IMP(a_ready_stall, aclk, aresetn, m_valid && !m_ready, !s_ready)
    `LSPG_ASSERT_NXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `LSPG_ASSERT_NXT(a_flow, aclk, aresetn, s_ready && v3_reg, m_valid)
endmodule
`default_nettype wire
